// ----- sv/mme_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types and constants of the modular exponentiation block.
// ----------------------------------------------------------------------------
package mme_pkg;

    // sequencer states of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_STEP,
        ST_EMIT
    } mme_state_t;

    // status of one modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } mme_mul_status_t;

    // register index of the modulus
    localparam logic REG_MODULUS = 1'b0;

endpackage

// ----- sv/mme_modmul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_modmul
// Bit-serial interleaved modular multiplier: x * y mod m, one bit of y per
// cycle, most significant first. Needs x <= m.
// ----------------------------------------------------------------------------
module mme_modmul #(
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [WIDTH-1:0]         x_in,
    input  logic [WIDTH-1:0]         y_in,
    input  logic [WIDTH-1:0]         m_in,
    output logic [WIDTH-1:0]         result,
    output mme_pkg::mme_mul_status_t status
);
    import mme_pkg::*;

    localparam int CW = $clog2(WIDTH);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] x_reg, x_next;
    logic [WIDTH-1:0] y_reg, y_next;
    logic [WIDTH-1:0] m_reg, m_next;
    logic [WIDTH-1:0] dbl;
    logic [WIDTH-1:0] sum;

    function automatic logic [WIDTH-1:0] add_mod(
        input logic [WIDTH-1:0] a,
        input logic [WIDTH-1:0] b,
        input logic [WIDTH-1:0] mm
    );
        logic [WIDTH-1:0] gap;
        begin
            gap = mm - b;
            if (a >= gap) begin
                add_mod = a - gap;
            end else begin
                add_mod = a + b;
            end
        end
    endfunction

    always_comb begin
        dbl = add_mod(acc_reg, acc_reg, m_reg);
        sum = y_reg[WIDTH-1] ? add_mod(dbl, x_reg, m_reg) : dbl;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        m_next    = m_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(WIDTH - 1);
            acc_next  = '0;
            x_next    = x_in;
            y_next    = y_in;
            m_next    = m_in;
        end else if (busy_reg) begin
            acc_next = sum;
            y_next   = {y_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        m_reg   <= m_next;
    end

    assign result      = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ----- sv/modular_exponentiation.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square and multiply: base^exponent mod modulus, using two
// bit-serial modular multipliers (one squares the base, one updates the
// running result) that run side by side for each exponent bit.
// ----------------------------------------------------------------------------
//  channel   direction  ports            contents
//  s_        in         s_tdata          base, exponent
//  m_        out        m_tdata/m_tuser  power / error
//  apb       in/out     psel..prdata     modulus at register 0
//
//  an item reduces the base, then runs one multiplier pass per exponent bit,
//  up to the highest set bit of the exponent; this multiplier loop sets the
//  run time of an item
//  a zero modulus skips the multipliers and answers with the error flag set
//  a new item is taken while the previous result waits in the output register
//  reset is synchronous and clears the modulus to 1
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // apb configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [((WIDTH > 32) ? 3 : 2):0]       paddr,
    input  logic [((WIDTH > 32) ? 64 : 32)-1:0]   pwdata,
    output logic [((WIDTH > 32) ? 64 : 32)-1:0]   prdata,
    output logic                                  pready,
    // input items
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((2*WIDTH + 7) / 8) * 8 - 1:0]  s_tdata,  // base, exponent
    // result items
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((WIDTH + 7) / 8) * 8 - 1:0]    m_tdata,  // power
    output logic                                  m_tuser   // error
);
    import mme_pkg::*;

    localparam int ADDR_LSB = (WIDTH > 32) ? 3 : 2;
    localparam int DW       = (WIDTH > 32) ? 64 : 32;
    localparam int OUT_W    = ((WIDTH + 7) / 8) * 8;

    mme_state_t       state_reg, state_next;
    logic [WIDTH-1:0] modulus_reg, modulus_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [WIDTH-1:0] e_reg, e_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] power_reg, power_next;
    logic             err_reg, err_next;
    logic             out_err_reg, out_err_next;
    logic             mvalid_reg, mvalid_next;

    logic             s_fire;
    logic             mod_zero;
    logic             load_out;
    logic             sqr_start, mul_start;
    logic [WIDTH-1:0] sqr_x, sqr_y;
    logic [WIDTH-1:0] sqr_res, mul_res;
    logic [WIDTH-1:0] s_base, s_exponent;
    logic             cfg_write;

    mme_mul_status_t  sqr_st, mul_st;

    assign s_base     = s_tdata[WIDTH-1:0];
    assign s_exponent = s_tdata[2*WIDTH-1:WIDTH];
    assign s_fire     = s_tvalid && s_tready;
    assign mod_zero   = (modulus_reg == '0);

    // apb
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[ADDR_LSB] == REG_MODULUS);
    assign prdata    = (paddr[ADDR_LSB] == REG_MODULUS) ? DW'(modulus_reg) : '0;
    assign modulus_next = cfg_write ? pwdata[WIDTH-1:0] : modulus_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = mod_zero ? ST_EMIT : ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (sqr_st.done) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = (e_reg == '0) ? ST_EMIT : ST_STEP;
            end
            ST_STEP: begin
                if (sqr_st.done) begin
                    state_next = ST_CHECK;
                end
            end
            ST_EMIT: begin
                if (!mvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready  = 1'b0;
        sqr_start = 1'b0;
        mul_start = 1'b0;
        sqr_x     = b_reg;
        sqr_y     = b_reg;
        load_out  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                sqr_x     = WIDTH'(1);
                sqr_y     = s_base;
                sqr_start = s_fire && !mod_zero;
            end
            ST_CHECK: begin
                sqr_start = (e_reg != '0);
                mul_start = (e_reg != '0) && e_reg[0];
            end
            ST_EMIT: begin
                load_out = !mvalid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        b_next       = b_reg;
        e_next       = e_reg;
        acc_next     = acc_reg;
        err_next     = err_reg;
        power_next   = power_reg;
        out_err_next = out_err_reg;
        mvalid_next  = mvalid_reg && !m_tready;
        if (s_fire) begin
            e_next   = s_exponent;
            err_next = mod_zero;
            acc_next = mod_zero ? '0 : WIDTH'(1);
        end
        if (state_reg == ST_REDUCE && sqr_st.done) begin
            b_next = sqr_res;
        end
        if (state_reg == ST_STEP && sqr_st.done) begin
            b_next = sqr_res;
            e_next = {1'b0, e_reg[WIDTH-1:1]};
            if (e_reg[0]) begin
                acc_next = mul_res;
            end
        end
        if (load_out) begin
            power_next   = acc_reg;
            out_err_next = err_reg;
            mvalid_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            modulus_reg <= WIDTH'(1);
            mvalid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            modulus_reg <= modulus_next;
            mvalid_reg  <= mvalid_next;
        end
        b_reg       <= b_next;
        e_reg       <= e_next;
        acc_reg     <= acc_next;
        err_reg     <= err_next;
        power_reg   <= power_next;
        out_err_reg <= out_err_next;
    end

    mme_modmul #(
        .WIDTH (WIDTH)
    ) u_sqr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqr_start),
        .x_in    (sqr_x),
        .y_in    (sqr_y),
        .m_in    (modulus_reg),
        .result  (sqr_res),
        .status  (sqr_st)
    );

    mme_modmul #(
        .WIDTH (WIDTH)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .x_in    (acc_reg),
        .y_in    (b_reg),
        .m_in    (modulus_reg),
        .result  (mul_res),
        .status  (mul_st)
    );

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = OUT_W'(power_reg);
    assign m_tuser  = out_err_reg;

    // the running-result multiplier finishes with the squarer
    logic unused_mul;
    assign unused_mul = mul_st.busy ^ mul_st.done ^ sqr_st.busy
                        ^ (|paddr[ADDR_LSB-1:0]) ^ (|pwdata);

endmodule
